[hw/rtl/pse_pkg.sv]
// package with shared constants, codes and types of the postfix evaluator
`timescale 1ns / 1ps
package pse_pkg;

  // default sizes
  localparam int unsigned StackDepth = 32;
  localparam int unsigned VarCount   = 32;
  localparam int unsigned DataWidth  = 32;

  // widths fixed by the token and result fields
  localparam int unsigned KindW = 2;
  localparam int unsigned OpW   = 5;
  localparam int unsigned LitW  = 32;
  localparam int unsigned VidxW = 5;
  localparam int unsigned ResW  = 32;
  localparam int unsigned StW   = 2;

  // token kinds as they arrive
  typedef enum logic [KindW-1:0] {
    TK_NUMBER   = 2'd0,
    TK_VARIABLE = 2'd1,
    TK_OPERATOR = 2'd2,
    TK_NONE     = 2'd3
  } token_kind_e;

  // classified commands handed to the back part
  typedef enum logic [1:0] {
    CMD_PUSH_LIT = 2'd0,
    CMD_PUSH_REF = 2'd1,
    CMD_OPER     = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_e;

  // operator codes
  typedef enum logic [OpW-1:0] {
    OP_ASSIGN = 5'd0,
    OP_LBRACK = 5'd1,
    OP_RBRACK = 5'd2,
    OP_LOR    = 5'd3,
    OP_LAND   = 5'd4,
    OP_BOR    = 5'd5,
    OP_BXOR   = 5'd6,
    OP_BAND   = 5'd7,
    OP_EQ     = 5'd8,
    OP_NE     = 5'd9,
    OP_LE     = 5'd10,
    OP_LT     = 5'd11,
    OP_GE     = 5'd12,
    OP_GT     = 5'd13,
    OP_SHL    = 5'd14,
    OP_SHR    = 5'd15,
    OP_ADD    = 5'd16,
    OP_SUB    = 5'd17,
    OP_MUL    = 5'd18,
    OP_DIV    = 5'd19,
    OP_MOD    = 5'd20
  } op_e;

  // result status codes
  typedef enum logic [StW-1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_e;

  // modes of the iterative multiply / divide unit
  typedef enum logic [1:0] {
    MD_MUL = 2'd0,
    MD_DIV = 2'd1,
    MD_REM = 2'd2
  } md_mode_e;

endpackage

[hw/rtl/pse_if.sv]
// token and result channel interfaces
`timescale 1ns / 1ps
interface pse_tok_if;
  logic                           valid;
  logic                           ready;
  logic [pse_pkg::KindW-1:0]      token_kind;
  logic [pse_pkg::OpW-1:0]        op;
  logic signed [pse_pkg::LitW-1:0] literal;
  logic [pse_pkg::VidxW-1:0]      var_index;
  logic                           last;

  modport source (output valid, token_kind, op, literal, var_index, last, input ready);
  modport sink   (input valid, token_kind, op, literal, var_index, last, output ready);
endinterface

interface pse_res_if;
  logic                            valid;
  logic                            ready;
  logic signed [pse_pkg::ResW-1:0] result;
  logic [pse_pkg::StW-1:0]         status;
  logic                            div_by_zero;

  modport source (output valid, result, status, div_by_zero, input ready);
  modport sink   (input valid, result, status, div_by_zero, output ready);
endinterface

[hw/rtl/pse_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
module pse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/pse_front.sv]
// front part: accepts tokens and classifies them into commands
`timescale 1ns / 1ps
module pse_front #(
  parameter int unsigned VAR_COUNT  = pse_pkg::VarCount,
  parameter int unsigned DATA_WIDTH = pse_pkg::DataWidth,
  localparam int unsigned VIW  = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1,
  localparam int unsigned CMDW = 2 + pse_pkg::OpW + DATA_WIDTH + VIW + 1
) (
  pse_tok_if.sink         tok_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output logic [CMDW-1:0] cmd_data_o
);

  localparam int unsigned NIDX = 2 ** pse_pkg::VidxW;

  logic [VIW-1:0]        idx_tbl [NIDX];
  pse_pkg::cmd_e         kind;
  logic [DATA_WIDTH-1:0] lit_ext;

  // index folding table, worked out at elaboration
  for (genvar g = 0; g < NIDX; g++) begin : g_idx
    assign idx_tbl[g] = VIW'(g % VAR_COUNT);
  end

  // classify the token kind
  always_comb begin
    case (pse_pkg::token_kind_e'(tok_i.token_kind))
      pse_pkg::TK_NUMBER:   kind = pse_pkg::CMD_PUSH_LIT;
      pse_pkg::TK_VARIABLE: kind = pse_pkg::CMD_PUSH_REF;
      pse_pkg::TK_OPERATOR: kind = pse_pkg::CMD_OPER;
      default:              kind = pse_pkg::CMD_NOP;
    endcase
  end

  // literal sign extended or wrapped to the data width
  assign lit_ext = DATA_WIDTH'(tok_i.literal);

  assign cmd_valid_o = tok_i.valid;
  assign tok_i.ready = cmd_ready_i;
  assign cmd_data_o  = {kind, tok_i.op, lit_ext, idx_tbl[tok_i.var_index], tok_i.last};

endmodule

[hw/rtl/pse_queue.sv]
// two entry command queue between front and back
`timescale 1ns / 1ps
module pse_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] buf_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       fill_q, fill_d;
  logic             do_push, do_pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_data_o   = buf_q[rd_ptr_q];
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_valid_o & pop_ready_i;

  // pointer and fill update
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    fill_d   = fill_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[hw/rtl/pse_muldiv.sv]
// iterative multiply and signed divide / remainder, one bit per cycle
`timescale 1ns / 1ps
module pse_muldiv #(
  parameter int unsigned DATA_WIDTH = pse_pkg::DataWidth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  pse_pkg::md_mode_e     mode_i,
  input  logic [DATA_WIDTH-1:0] a_i,
  input  logic [DATA_WIDTH-1:0] b_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] res_o,
  output logic                  dz_o
);

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned CW = $clog2(DW + 1);

  typedef enum logic [2:0] {
    MS_IDLE = 3'b001,
    MS_RUN  = 3'b010,
    MS_END  = 3'b100
  } md_state_e;

  md_state_e         state_q, state_d;
  pse_pkg::md_mode_e mode_q, mode_d;
  logic              na_q, na_d, nb_q, nb_d, zero_q, zero_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DW-1:0]     x_q, x_d, y_q, y_d, acc_q, acc_d;
  logic [DW:0]       rem_sh, diff;

  assign rem_sh = {acc_q, x_q[DW-1]};
  assign diff   = rem_sh - {1'b0, y_q};

  // sequencer and datapath step
  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    na_d    = na_q;
    nb_d    = nb_q;
    zero_d  = zero_q;
    cnt_d   = cnt_q;
    x_d     = x_q;
    y_d     = y_q;
    acc_d   = acc_q;
    case (state_q)
      MS_IDLE: begin
        if (start_i) begin
          mode_d = mode_i;
          na_d   = a_i[DW-1];
          nb_d   = b_i[DW-1];
          zero_d = (b_i == '0);
          cnt_d  = CW'(DW);
          acc_d  = '0;
          if (mode_i == pse_pkg::MD_MUL) begin
            x_d     = b_i;
            y_d     = a_i;
            state_d = MS_RUN;
          end else begin
            x_d     = a_i[DW-1] ? (DW'(0) - a_i) : a_i;
            y_d     = b_i[DW-1] ? (DW'(0) - b_i) : b_i;
            state_d = (b_i == '0) ? MS_END : MS_RUN;
          end
        end
      end
      MS_RUN: begin
        if (mode_q == pse_pkg::MD_MUL) begin
          // shift and add
          if (x_q[0]) begin
            acc_d = acc_q + y_q;
          end
          x_d = x_q >> 1;
          y_d = y_q << 1;
        end else if (!diff[DW]) begin
          // restoring divide, subtract fits
          acc_d = diff[DW-1:0];
          x_d   = {x_q[DW-2:0], 1'b1};
        end else begin
          acc_d = rem_sh[DW-1:0];
          x_d   = {x_q[DW-2:0], 1'b0};
        end
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          state_d = MS_END;
        end
      end
      MS_END: begin
        state_d = MS_IDLE;
      end
      default: begin
        state_d = MS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    na_q   <= na_d;
    nb_q   <= nb_d;
    zero_q <= zero_d;
    cnt_q  <= cnt_d;
    x_q    <= x_d;
    y_q    <= y_d;
    acc_q  <= acc_d;
  end

  // sign fixup of the final value
  always_comb begin
    case (mode_q)
      pse_pkg::MD_MUL: res_o = acc_q;
      pse_pkg::MD_DIV: res_o = zero_q ? '0 : ((na_q != nb_q) ? (DW'(0) - x_q) : x_q);
      pse_pkg::MD_REM: res_o = zero_q ? '0 : (na_q ? (DW'(0) - acc_q) : acc_q);
      default:         res_o = '0;
    endcase
  end

  assign done_o = (state_q == MS_END);
  assign dz_o   = zero_q & (mode_q != pse_pkg::MD_MUL);

  // a run never continues with a spent counter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == MS_RUN) |-> (cnt_q != '0))
    else $error("muldiv running with spent counter");
  // a zero divisor never enters the iterations
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == MS_RUN && mode_q != pse_pkg::MD_MUL) |-> !zero_q)
    else $error("divide by zero iterating");
  // done lasts one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("muldiv done held");

endmodule

[hw/rtl/pse_back.sv]
// back part: operand stack, variable file and operator execution
`timescale 1ns / 1ps
module pse_back #(
  parameter int unsigned STACK_DEPTH = pse_pkg::StackDepth,
  parameter int unsigned VAR_COUNT   = pse_pkg::VarCount,
  parameter int unsigned DATA_WIDTH  = pse_pkg::DataWidth,
  localparam int unsigned VIW  = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1,
  localparam int unsigned CMDW = 2 + pse_pkg::OpW + DATA_WIDTH + VIW + 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  logic [CMDW-1:0] cmd_data_i,
  pse_res_if.source       res_o
);

  localparam int unsigned DW   = DATA_WIDTH;
  localparam int unsigned AW   = $clog2(STACK_DEPTH);
  localparam int unsigned CNTW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SW   = 1 + VIW + DW;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOAD   = 6'b000010,
    S_EXEC   = 6'b000100,
    S_MD     = 6'b001000,
    S_FIN_RD = 6'b010000,
    S_FIN    = 6'b100000
  } back_state_e;

  // command fields
  logic [1:0]              c_kind_raw;
  pse_pkg::cmd_e           c_kind;
  logic [pse_pkg::OpW-1:0] c_op;
  logic [DW-1:0]           c_lit;
  logic [VIW-1:0]          c_vidx;
  logic                    c_last;

  assign {c_kind_raw, c_op, c_lit, c_vidx, c_last} = cmd_data_i;
  assign c_kind = pse_pkg::cmd_e'(c_kind_raw);

  back_state_e             state_q, state_d;
  logic [CNTW-1:0]         count_q, count_d;
  logic                    abort_q, abort_d, ovf_q, ovf_d, dz_q, dz_d;
  logic [DW-1:0]           top_val_q, top_val_d;
  logic                    top_ref_q, top_ref_d;
  logic [VIW-1:0]          top_idx_q, top_idx_d;
  logic [pse_pkg::OpW-1:0] op_q, op_d;
  logic                    last_q, last_d;
  logic [DW-1:0]           left_val_q, left_val_d, b_q, b_d;
  logic                    left_ref_q, left_ref_d;
  logic [VIW-1:0]          left_idx_q, left_idx_d;
  logic                    out_vld_q, out_vld_d;
  logic [pse_pkg::ResW-1:0] out_res_q, out_res_d;
  pse_pkg::status_e        out_st_q, out_st_d;
  logic                    out_dz_q, out_dz_d;

  // memories
  logic           st_we, st_re;
  logic [AW-1:0]  st_waddr, st_raddr;
  logic [SW-1:0]  st_wdata, st_rdata;
  logic           v_we, v_re;
  logic [VIW-1:0] v_waddr, v_raddr;
  logic [DW-1:0]  v_wdata, v_rdata;
  logic           vld_q [VAR_COUNT];
  logic           vrd_vld_q;

  // muldiv unit
  logic              md_start, md_done, md_dz;
  pse_pkg::md_mode_e md_mode;
  logic [DW-1:0]     md_res;

  // operand values
  logic [DW-1:0] var_val, a_val, top_value, alu_res;
  logic [4:0]    sh;
  logic          lt_ab, lt_ba;
  logic          st_rd_ref;
  logic [VIW-1:0] st_rd_idx;
  logic [DW-1:0]  st_rd_val;

  assign var_val   = vrd_vld_q ? v_rdata : '0;
  assign a_val     = left_ref_q ? var_val : left_val_q;
  assign top_value = top_ref_q ? var_val : top_val_q;
  assign {st_rd_ref, st_rd_idx, st_rd_val} = st_rdata;
  assign sh    = b_q[4:0];
  assign lt_ab = ($signed(a_val) < $signed(b_q));
  assign lt_ba = ($signed(b_q) < $signed(a_val));

  // combinational operators
  always_comb begin
    case (pse_pkg::op_e'(op_q))
      pse_pkg::OP_ASSIGN: alu_res = left_ref_q ? b_q : left_val_q;
      pse_pkg::OP_LOR:    alu_res = DW'((a_val != '0) || (b_q != '0));
      pse_pkg::OP_LAND:   alu_res = DW'((a_val != '0) && (b_q != '0));
      pse_pkg::OP_BOR:    alu_res = a_val | b_q;
      pse_pkg::OP_BXOR:   alu_res = a_val ^ b_q;
      pse_pkg::OP_BAND:   alu_res = a_val & b_q;
      pse_pkg::OP_EQ:     alu_res = DW'(a_val == b_q);
      pse_pkg::OP_NE:     alu_res = DW'(a_val != b_q);
      pse_pkg::OP_LE:     alu_res = DW'(!lt_ba);
      pse_pkg::OP_LT:     alu_res = DW'(lt_ab);
      pse_pkg::OP_GE:     alu_res = DW'(!lt_ab);
      pse_pkg::OP_GT:     alu_res = DW'(lt_ba);
      pse_pkg::OP_SHL:    alu_res = a_val << sh;
      pse_pkg::OP_SHR:    alu_res = DW'($signed(a_val) >>> sh);
      pse_pkg::OP_ADD:    alu_res = a_val + b_q;
      pse_pkg::OP_SUB:    alu_res = a_val - b_q;
      default:            alu_res = '0;
    endcase
  end

  // muldiv mode from the operator
  always_comb begin
    case (pse_pkg::op_e'(op_q))
      pse_pkg::OP_DIV: md_mode = pse_pkg::MD_DIV;
      pse_pkg::OP_MOD: md_mode = pse_pkg::MD_REM;
      default:         md_mode = pse_pkg::MD_MUL;
    endcase
  end

  assign cmd_ready_o = (state_q == S_IDLE);

  // sequencer
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    abort_d    = abort_q;
    ovf_d      = ovf_q;
    dz_d       = dz_q;
    top_val_d  = top_val_q;
    top_ref_d  = top_ref_q;
    top_idx_d  = top_idx_q;
    op_d       = op_q;
    last_d     = last_q;
    left_val_d = left_val_q;
    left_ref_d = left_ref_q;
    left_idx_d = left_idx_q;
    b_d        = b_q;
    out_vld_d  = out_vld_q & ~res_o.ready;
    out_res_d  = out_res_q;
    out_st_d   = out_st_q;
    out_dz_d   = out_dz_q;
    st_we      = 1'b0;
    st_waddr   = count_q[AW-1:0];
    st_wdata   = '0;
    st_re      = 1'b0;
    st_raddr   = AW'(count_q - CNTW'(2));
    v_we       = 1'b0;
    v_waddr    = left_idx_q;
    v_wdata    = b_q;
    v_re       = 1'b0;
    v_raddr    = top_idx_q;
    md_start   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          op_d   = c_op;
          last_d = c_last;
          if (c_last) begin
            state_d = S_FIN_RD;
          end
          if (!abort_q) begin
            case (c_kind)
              pse_pkg::CMD_PUSH_LIT, pse_pkg::CMD_PUSH_REF: begin
                if (count_q == CNTW'(STACK_DEPTH)) begin
                  ovf_d = 1'b1;
                end else begin
                  st_we     = 1'b1;
                  top_ref_d = (c_kind == pse_pkg::CMD_PUSH_REF);
                  top_idx_d = c_vidx;
                  top_val_d = top_ref_d ? '0 : c_lit;
                  st_wdata  = {top_ref_d, c_vidx, top_val_d};
                  count_d   = count_q + CNTW'(1);
                end
              end
              pse_pkg::CMD_OPER: begin
                if (count_q < CNTW'(2)) begin
                  abort_d = 1'b1;
                end else begin
                  // fetch the left entry and the right variable
                  st_re   = 1'b1;
                  v_re    = 1'b1;
                  state_d = S_LOAD;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_LOAD: begin
        b_d        = top_value;
        left_ref_d = st_rd_ref;
        left_idx_d = st_rd_idx;
        left_val_d = st_rd_val;
        v_re       = 1'b1;
        v_raddr    = st_rd_idx;
        state_d    = S_EXEC;
      end
      S_EXEC: begin
        if (pse_pkg::op_e'(op_q) == pse_pkg::OP_MUL ||
            pse_pkg::op_e'(op_q) == pse_pkg::OP_DIV ||
            pse_pkg::op_e'(op_q) == pse_pkg::OP_MOD) begin
          md_start = 1'b1;
          state_d  = S_MD;
        end else begin
          if (pse_pkg::op_e'(op_q) == pse_pkg::OP_ASSIGN && left_ref_q) begin
            v_we = 1'b1;
          end
          st_we     = 1'b1;
          st_waddr  = AW'(count_q - CNTW'(2));
          st_wdata  = {1'b0, VIW'(0), alu_res};
          top_val_d = alu_res;
          top_ref_d = 1'b0;
          count_d   = count_q - CNTW'(1);
          state_d   = last_q ? S_FIN_RD : S_IDLE;
        end
      end
      S_MD: begin
        if (md_done) begin
          dz_d      = dz_q | md_dz;
          st_we     = 1'b1;
          st_waddr  = AW'(count_q - CNTW'(2));
          st_wdata  = {1'b0, VIW'(0), md_res};
          top_val_d = md_res;
          top_ref_d = 1'b0;
          count_d   = count_q - CNTW'(1);
          state_d   = last_q ? S_FIN_RD : S_IDLE;
        end
      end
      S_FIN_RD: begin
        v_re    = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_vld_q || res_o.ready) begin
          out_vld_d = 1'b1;
          out_dz_d  = dz_q;
          if (ovf_q) begin
            out_st_d  = pse_pkg::ST_OVERFLOW;
            out_res_d = '0;
          end else if (count_q == CNTW'(1)) begin
            out_st_d  = pse_pkg::ST_OK;
            out_res_d = pse_pkg::ResW'(top_value);
          end else begin
            out_st_d  = pse_pkg::ST_MALFORMED;
            out_res_d = '0;
          end
          count_d = '0;
          abort_d = 1'b0;
          ovf_d   = 1'b0;
          dz_d    = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      abort_q   <= 1'b0;
      ovf_q     <= 1'b0;
      dz_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      abort_q   <= abort_d;
      ovf_q     <= ovf_d;
      dz_q      <= dz_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    top_val_q  <= top_val_d;
    top_ref_q  <= top_ref_d;
    top_idx_q  <= top_idx_d;
    op_q       <= op_d;
    last_q     <= last_d;
    left_val_q <= left_val_d;
    left_ref_q <= left_ref_d;
    left_idx_q <= left_idx_d;
    b_q        <= b_d;
    out_res_q  <= out_res_d;
    out_st_q   <= out_st_d;
    out_dz_q   <= out_dz_d;
  end

  // variable valid bits, an unwritten variable reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VAR_COUNT; i++) begin
        vld_q[i] <= 1'b0;
      end
      vrd_vld_q <= 1'b0;
    end else begin
      if (v_we) begin
        vld_q[v_waddr] <= 1'b1;
      end
      if (v_re) begin
        vrd_vld_q <= vld_q[v_raddr];
      end
    end
  end

  pse_ram #(.WIDTH(SW), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  pse_ram #(.WIDTH(DW), .DEPTH(VAR_COUNT)) u_var_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .re_i    (v_re),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  pse_muldiv #(.DATA_WIDTH(DW)) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .mode_i  (md_mode),
    .a_i     (a_val),
    .b_i     (b_q),
    .done_o  (md_done),
    .res_o   (md_res),
    .dz_o    (md_dz)
  );

  assign res_o.valid       = out_vld_q;
  assign res_o.result      = out_res_q;
  assign res_o.status      = out_st_q;
  assign res_o.div_by_zero = out_dz_q;

  // stack never holds more than its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(STACK_DEPTH))
    else $error("stack count beyond depth");
  // an operator only executes with two operands present
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC || state_q == S_MD) |-> (count_q >= CNTW'(2)))
    else $error("operator without two operands");
  // finishing an expression clears the stack and flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && (!out_vld_q || res_o.ready))
      |=> (count_q == '0 && !abort_q && !ovf_q && !dz_q && out_vld_q))
    else $error("expression end did not clear state");

endmodule

[hw/rtl/postfix_stack_evaluator_top.sv]
// top level of the postfix stack expression evaluator
//
// tokens arrive on tok_i (valid/ready); a request is taken when both are
// high. number and variable tokens push, operator tokens pop two entries
// and push one. the token flagged last yields one request on res_o with
// the value, a status and the divide-by-zero flag.
// a two entry queue sits between token classification and execution, so
// tokens keep flowing while the evaluator works, until the queue is full.
// a push is taken in the idle state; an operator loads, then executes;
// multiply, divide and modulo also wait for the one-bit-per-cycle unit.
// the last token passes a final read state before the result register.
// a finished result waits in its output register while res_o is stalled;
// execution continues until the next last token finds it still occupied.
// reset clears the stack, flags, queue and the variable valid bits, so all
// variables read as zero; the variable file persists across expressions.
// no clearing pass is needed after reset.
`timescale 1ns / 1ps
module postfix_stack_evaluator_top #(
  parameter int unsigned STACK_DEPTH = pse_pkg::StackDepth,
  parameter int unsigned VAR_COUNT   = pse_pkg::VarCount,
  parameter int unsigned DATA_WIDTH  = pse_pkg::DataWidth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pse_tok_if.sink    tok_i,
  pse_res_if.source  res_o
);

  localparam int unsigned VIW  = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
  localparam int unsigned CMDW = 2 + pse_pkg::OpW + DATA_WIDTH + VIW + 1;

  logic            f_valid, f_ready, b_valid, b_ready;
  logic [CMDW-1:0] f_data, b_data;

  pse_front #(.VAR_COUNT(VAR_COUNT), .DATA_WIDTH(DATA_WIDTH)) u_front (
    .tok_i       (tok_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_data_o  (f_data)
  );

  pse_queue #(.WIDTH(CMDW)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_data),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_data)
  );

  pse_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .VAR_COUNT   (VAR_COUNT),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_data_i  (b_data),
    .res_o       (res_o)
  );

endmodule
